// ===== src/bst_pkg.sv =====
`default_nettype none
package bst_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int MinSide   = 3;
  localparam int CfgW      = 11;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int HgtW      = $clog2(MaxHeight);
  // rows run past the frame by up to three while the pipeline drains
  localparam int RowW      = $clog2(MaxHeight + 3);
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFrameHeight = CfgIdxW'(1);

  // one column of the window: [2] top, [1] middle, [0] bottom
  typedef logic [2:0] col3_t;

  typedef struct packed {
    col3_t west;
    col3_t mid;
    col3_t east;
  } win_t;

  // window center sits on a frame border: neighbors beyond it read as 0
  typedef struct packed {
    logic n;
    logic s;
    logic w;
    logic e;
  } bord_t;

  // control for one accepted item
  typedef struct packed {
    logic            go;
    logic            pix;
    logic [ColW-1:0] kcol;
    logic            m_on;
    logic            m_in;
    logic [ColW-1:0] mcol;
    bord_t           mb;
    logic            o_on;
    bord_t           ob;
    logic            last;
  } item_t;

  typedef struct packed {
    logic            go;
    logic            pix;
    logic [ColW-1:0] mcol;
    logic            o_on;
    bord_t           ob;
    logic            last;
  } mid_t;

  // one thinning subpass on the center pixel
  function automatic logic thin_keep(win_t w, bord_t b, logic second);
    logic [7:0] ring;
    logic [7:0] nxt;
    logic [3:0] sum;
    logic [3:0] tcnt;
    logic       p2, p4, p6, p8;
    logic       prod_ok;
    logic       del;
    p2 = w.mid[2] & ~b.n;
    p4 = w.east[1] & ~b.e;
    p6 = w.mid[0] & ~b.s;
    p8 = w.west[1] & ~b.w;
    // ring[0] is P2 (north), then clockwise up to ring[7] = P9 (northwest)
    ring = {w.west[2] & ~b.n & ~b.w,
            p8,
            w.west[0] & ~b.s & ~b.w,
            p6,
            w.east[0] & ~b.s & ~b.e,
            p4,
            w.east[2] & ~b.n & ~b.e,
            p2};
    nxt  = {ring[0], ring[7:1]};
    sum  = 4'($countones(ring));
    tcnt = 4'($countones(~ring & nxt));
    if (second) begin
      prod_ok = !(p2 && p4 && p8) && !(p2 && p6 && p8);
    end else begin
      prod_ok = !(p2 && p4 && p6) && !(p4 && p6 && p8);
    end
    del = (sum >= 4'd2) && (sum <= 4'd6) && (tcnt == 4'd1) && prod_ok;
    return w.mid[1] & ~del;
  endfunction

endpackage
`default_nettype wire

// ===== src/bst_ctrl.sv =====
`default_nettype none
module bst_ctrl
  import bst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               fire_i,
  input  wire logic               pix_i,
  input  wire logic               flush_i,
  output item_t                   item_o
);

  logic [CfgW-1:0] frame_w_q, frame_h_q;
  logic            busy_q;
  logic [ColW-1:0] wm1_q, wm1_d;
  logic [HgtW-1:0] hm1_q, hm1_d;
  logic [ColW-1:0] k_col_q, k_col_d, m_col_q, m_col_d, o_col_q, o_col_d;
  logic [RowW-1:0] k_row_q, k_row_d, m_row_q, m_row_d, o_row_q, o_row_d;
  logic            m_on_q, m_on_d, o_on_q, o_on_d;
  logic [RowW-1:0] hm1_row;
  logic            k_in;

  // side length held within MinSide..max, then minus one
  function automatic logic [ColW-1:0] side_m1(logic [CfgW-1:0] v, int unsigned hi);
    logic [CfgW-1:0] c;
    if (v < CfgW'(MinSide)) begin
      c = CfgW'(MinSide);
    end else if (v > CfgW'(hi)) begin
      c = CfgW'(hi);
    end else begin
      c = v;
    end
    return ColW'(c - CfgW'(1));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= CfgW'(640);
      frame_h_q <= CfgW'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFrameWidth:  frame_w_q <= cfg_data_i;
        RegFrameHeight: frame_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // geometry is latched at the first item of a frame
  assign wm1_d   = busy_q ? wm1_q : side_m1(frame_w_q, MaxWidth);
  assign hm1_d   = busy_q ? hm1_q : HgtW'(side_m1(frame_h_q, MaxHeight));
  assign hm1_row = RowW'(hm1_d);

  assign k_in = (k_row_q <= hm1_row);

  always_comb begin
    item_o.go   = !(flush_i && k_in);
    item_o.pix  = pix_i & k_in;
    item_o.kcol = k_col_q;
    item_o.m_on = m_on_q;
    item_o.m_in = (m_row_q <= hm1_row);
    item_o.mcol = m_col_q;
    item_o.mb.n = (m_row_q == '0);
    item_o.mb.s = (m_row_q == hm1_row);
    item_o.mb.w = (m_col_q == '0);
    item_o.mb.e = (m_col_q == wm1_d);
    item_o.o_on = o_on_q;
    item_o.ob.n = (o_row_q == '0);
    item_o.ob.s = (o_row_q == hm1_row);
    item_o.ob.w = (o_col_q == '0);
    item_o.ob.e = (o_col_q == wm1_d);
    item_o.last = o_on_q && (o_row_q == hm1_row) && (o_col_q == wm1_d);
  end

  always_comb begin
    k_col_d = k_col_q;
    k_row_d = k_row_q;
    m_col_d = m_col_q;
    m_row_d = m_row_q;
    o_col_d = o_col_q;
    o_row_d = o_row_q;
    m_on_d  = m_on_q;
    o_on_d  = o_on_q;
    if (k_col_q == wm1_d) begin
      k_col_d = '0;
      k_row_d = k_row_q + RowW'(1);
    end else begin
      k_col_d = k_col_q + ColW'(1);
    end
    if (m_on_q) begin
      if (m_col_q == wm1_d) begin
        m_col_d = '0;
        m_row_d = m_row_q + RowW'(1);
      end else begin
        m_col_d = m_col_q + ColW'(1);
      end
    end else if (k_row_q == RowW'(1) && k_col_q == '0) begin
      m_on_d = 1'b1;
    end
    if (o_on_q) begin
      if (o_col_q == wm1_d) begin
        o_col_d = '0;
        o_row_d = o_row_q + RowW'(1);
      end else begin
        o_col_d = o_col_q + ColW'(1);
      end
    end else if (m_on_q && m_row_q == RowW'(1) && m_col_q == '0) begin
      o_on_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      wm1_q   <= '0;
      hm1_q   <= '0;
      k_col_q <= '0;
      k_row_q <= '0;
      m_col_q <= '0;
      m_row_q <= '0;
      o_col_q <= '0;
      o_row_q <= '0;
      m_on_q  <= 1'b0;
      o_on_q  <= 1'b0;
    end else if (fire_i && item_o.go) begin
      if (item_o.last) begin
        busy_q  <= 1'b0;
        k_col_q <= '0;
        k_row_q <= '0;
        m_col_q <= '0;
        m_row_q <= '0;
        o_col_q <= '0;
        o_row_q <= '0;
        m_on_q  <= 1'b0;
        o_on_q  <= 1'b0;
      end else begin
        busy_q  <= 1'b1;
        wm1_q   <= wm1_d;
        hm1_q   <= hm1_d;
        k_col_q <= k_col_d;
        k_row_q <= k_row_d;
        m_col_q <= m_col_d;
        m_row_q <= m_row_d;
        o_col_q <= o_col_d;
        o_row_q <= o_row_d;
        m_on_q  <= m_on_d;
        o_on_q  <= o_on_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/bst_window.sv =====
`default_nettype none
module bst_window
  import bst_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [ColW-1:0] rd_col_i,
  input  wire logic            shift_i,
  input  wire logic [ColW-1:0] wr_col_i,
  input  wire logic            pix_i,
  output win_t                 win_o
);

  // per column: [1] two rows up, [0] one row up
  logic [1:0] line_mem [MaxWidth];
  logic [1:0] rd_q;
  col3_t      west_q, mid_q;
  col3_t      east;

  assign east  = {rd_q[1], rd_q[0], pix_i};
  assign win_o = '{west: west_q, mid: mid_q, east: east};

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      line_mem[wr_col_i] <= {rd_q[0], pix_i};
    end
    if (rd_en_i) begin
      rd_q <= line_mem[rd_col_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      west_q <= '0;
      mid_q  <= '0;
    end else if (shift_i) begin
      west_q <= mid_q;
      mid_q  <= east;
    end
  end

endmodule
`default_nettype wire

// ===== src/binary_skeleton_thinning_unit.sv =====
// One Zhang-Suen iteration on a raster stream, one transfer per cycle while the output is not stalled.
// An accepted transfer moves through the s1 and s2 registers into the output register.
// A frame of W x H pixels takes W*H pixel transfers plus 2*(W+1) drain transfers, flush or not;
// the two 3x3 windows, each fed by a line memory of one read and one write a cycle, set this.
// Reset clears control state and loads 640 x 480; line memories need no clearing pass.
`default_nettype none
module binary_skeleton_thinning_unit
  import bst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,  // [0] pixel_in
  input  wire logic               s_axis_tuser,  // [0] flush
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [7:0]              m_axis_tdata,  // [0] pixel_out
  output logic                    m_axis_tlast
);

  item_t item, s1_q;
  mid_t  s2_q;
  win_t  win1, win2;
  logic  adv, fire;
  logic  res1, res2;
  logic  out_v_q, out_pix_q, out_last_q;

  assign adv           = !out_v_q || m_axis_tready;
  assign fire          = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  bst_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .fire_i  (fire),
    .pix_i   (s_axis_tdata[0]),
    .flush_i (s_axis_tuser),
    .item_o  (item)
  );

  bst_window u_win1 (
    .clk_i,
    .rst_ni,
    .rd_en_i  (adv),
    .rd_col_i (item.kcol),
    .shift_i  (adv && s1_q.go),
    .wr_col_i (s1_q.kcol),
    .pix_i    (s1_q.pix),
    .win_o    (win1)
  );

  // drop results for centers past the frame: the second pass sees them as 0
  assign res1 = thin_keep(win1, s1_q.mb, 1'b0) & s1_q.m_in;

  bst_window u_win2 (
    .clk_i,
    .rst_ni,
    .rd_en_i  (adv),
    .rd_col_i (s1_q.mcol),
    .shift_i  (adv && s2_q.go),
    .wr_col_i (s2_q.mcol),
    .pix_i    (s2_q.pix),
    .win_o    (win2)
  );

  assign res2 = thin_keep(win2, s2_q.ob, 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      s2_q       <= '0;
      out_v_q    <= 1'b0;
      out_pix_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else if (adv) begin
      if (fire) begin
        s1_q <= item;
      end else begin
        s1_q.go <= 1'b0;
      end
      s2_q.go    <= s1_q.go && s1_q.m_on;
      s2_q.pix   <= res1;
      s2_q.mcol  <= s1_q.mcol;
      s2_q.o_on  <= s1_q.o_on;
      s2_q.ob    <= s1_q.ob;
      s2_q.last  <= s1_q.last;
      out_v_q    <= s2_q.go && s2_q.o_on;
      out_pix_q  <= res2;
      out_last_q <= s2_q.last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_pix_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import bst_pkg::*;

  localparam int CycleLimit = 1_000_000;

  typedef struct packed {
    logic pix;
    logic last;
  } thin_px_t;

  // Holds its own copy of both line stores and the frame geometry, and
  // works out the thinned pixel due on each accepted transfer.
  class thinning_scoreboard;
    int reg_w;
    int reg_h;
    int frame_w;
    int frame_h;
    int pos;
    bit in_lines [4][MaxWidth];
    bit mid_lines[4][MaxWidth];
    thin_px_t pixels_due[$];
    int mismatches;

    function new();
      reg_w = 640;
      reg_h = 480;
      frame_w = MinSide;
      frame_h = MinSide;
      pos = 0;
      mismatches = 0;
      foreach (in_lines[r, c]) begin
        in_lines[r][c] = 1'b0;
        mid_lines[r][c] = 1'b0;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      if (idx == RegFrameWidth) reg_w = int'(val);
      else if (idx == RegFrameHeight) reg_h = int'(val);
    endfunction

    function int clamp_side(int v, int hi);
      if (v < MinSide) return MinSide;
      if (v > hi) return hi;
      return v;
    endfunction

    // pixels beyond the frame read as background
    function bit pixel_at(bit from_mid, int r, int c);
      if (r < 0 || c < 0 || r >= frame_h || c >= frame_w) return 1'b0;
      return from_mid ? mid_lines[r % 4][c] : in_lines[r % 4][c];
    endfunction

    function bit zs_keep(bit second, int p);
      int r;
      int c;
      int sum;
      int trans;
      bit [7:0] ring;
      r = p / frame_w;
      c = p % frame_w;
      sum = 0;
      trans = 0;
      if (!pixel_at(second, r, c)) return 1'b0;
      // ring[0] north, then clockwise to ring[7] northwest
      ring[0] = pixel_at(second, r - 1, c);
      ring[1] = pixel_at(second, r - 1, c + 1);
      ring[2] = pixel_at(second, r, c + 1);
      ring[3] = pixel_at(second, r + 1, c + 1);
      ring[4] = pixel_at(second, r + 1, c);
      ring[5] = pixel_at(second, r + 1, c - 1);
      ring[6] = pixel_at(second, r, c - 1);
      ring[7] = pixel_at(second, r - 1, c - 1);
      for (int k = 0; k < 8; k++) begin
        sum += ring[k];
        if (!ring[k] && ring[(k + 1) % 8]) trans++;
      end
      if (sum >= 2 && sum <= 6 && trans == 1) begin
        if (!second) begin
          if (!(ring[0] && ring[2] && ring[4]) && !(ring[2] && ring[4] && ring[6]))
            return 1'b0;
        end else begin
          if (!(ring[0] && ring[2] && ring[6]) && !(ring[0] && ring[4] && ring[6]))
            return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // returns 0 when the block drops the transfer
    function bit note_input(bit pix, bit flush);
      int total;
      int lag;
      int m;
      int o;
      thin_px_t px;
      if (pos == 0) begin
        if (flush) return 1'b0;
        frame_w = clamp_side(reg_w, MaxWidth);
        frame_h = clamp_side(reg_h, MaxHeight);
      end
      total = frame_w * frame_h;
      lag = frame_w + 1;
      if (pos < total) begin
        if (flush) return 1'b0;
        in_lines[(pos / frame_w) % 4][pos % frame_w] = pix;
      end
      if (pos >= lag) begin
        m = pos - lag;
        if (m < total) mid_lines[(m / frame_w) % 4][m % frame_w] = zs_keep(1'b0, m);
      end
      if (pos >= 2 * lag) begin
        o = pos - 2 * lag;
        px.pix = zs_keep(1'b1, o);
        px.last = (o + 1 >= total);
        pixels_due.insert(pixels_due.size(), px);
        pos = px.last ? 0 : pos + 1;
        return 1'b1;
      end
      pos++;
      return 1'b1;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic pix, logic last);
      thin_px_t px;
      if (pixels_due.size() == 0) begin
        report($sformatf("unexpected pixel %b last %b", pix, last));
      end else begin
        px = pixels_due.pop_front();
        if (pix !== px.pix) report($sformatf("pixel %b, want %b", pix, px.pix));
        if (last !== px.last) report($sformatf("tlast %b, want %b", last, px.last));
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegFrameWidth;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;   // [0] pixel_in
  logic               s_axis_tuser = 1'b0; // [0] flush
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;        // [0] pixel_out
  logic               m_axis_tlast;

  thinning_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int rx_mode = 0;
  int frame_items = 0;

  binary_skeleton_thinning_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: check accepted transfers, stall on a pattern that changes now and then
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[0], m_axis_tlast);
    if (cycles % 300 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (cycles % 7) > 2;
      default: m_axis_tready <= (cycles % 8) == 0;
    endcase
  end

  task automatic send_item(input bit pix, input bit flush);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk_i);
      else repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, pix};
    s_axis_tuser <= flush;
    do @(posedge clk_i); while (!s_axis_tready);
    void'(sb.note_input(pix, flush));
    burst_left--;
  endtask

  // hold off until every due pixel has come, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pixels_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_geometry(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegFrameWidth;
    cfg_data_i <= w;
    @(posedge clk_i);
    sb.write_reg(RegFrameWidth, w);
    cfg_idx_i <= RegFrameHeight;
    cfg_data_i <= h;
    @(posedge clk_i);
    sb.write_reg(RegFrameHeight, h);
    cfg_we_i <= 1'b0;
  endtask

  // one frame of random content at the given density, with random flushes, then the drain transfers
  task automatic send_frame(input int w, input int h, input int density);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(1'($urandom_range(0, 1)), 1'b1);
      send_item($urandom_range(1, 100) <= density, 1'b0);
    end
    // drain: a pixel here is discarded like a flush
    for (int i = 0; i < 2 * (w + 1); i++)
      send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    frame_items += w * h + 2 * (w + 1);
  endtask

  initial begin
    bit [8:0] shape;
    int w;
    int h;
    int density;
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clamped up to 3 x 3; idle flush, early flush, pixels while draining
    write_geometry(11'd0, 11'd1);
    send_item(1'b1, 1'b1);
    shape = 9'b110_111_011;
    for (int i = 0; i < 9; i++) begin
      send_item(shape[8 - i], 1'b0);
      if (i == 4) send_item(1'b0, 1'b1);
    end
    for (int i = 0; i < 8; i++) send_item(1'b1, 1'(i % 2));

    w = 3;
    h = 3;
    while (frame_items < 1350) begin
      if (frame_items == 0 || $urandom_range(0, 1) == 0) begin
        wait_idle();
        w = $urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 9);
        h = $urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 9);
        if ($urandom_range(0, 7) == 0) w = $urandom_range(12, 40);
        write_geometry(11'(w), 11'(h));
        w = (w < MinSide) ? MinSide : w;
        h = (h < MinSide) ? MinSide : h;
      end
      if ($urandom_range(0, 3) == 0) send_item(1'($urandom_range(0, 1)), 1'b1);
      case ($urandom_range(0, 4))
        0: density = 10;
        1: density = 40;
        2: density = 60;
        3: density = 85;
        default: density = 100;
      endcase
      send_frame(w, h, density);
    end

    s_axis_tvalid <= 1'b0;
    n = 0;
    while (n < 20000 && sb.pixels_due.size() != 0) begin
      @(posedge clk_i);
      n++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.pixels_due.size() != 0)
      sb.report($sformatf("%0d pixels never came", sb.pixels_due.size()));
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
